// File: sv/ftm_pkg.sv
package ftm_pkg;

    localparam int INDEX_WIDTH = 64;
    localparam int BIT_CNT_W   = $clog2(INDEX_WIDTH + 1);
    localparam int VAL_W       = 30;
    localparam int PROD_W      = 60;
    localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;

    // Barrett reduction of a sum below 2^61: quotient estimate is
    // ((sum >> 29) * MU) >> 33 with MU = floor(2^62 / PRIME); the estimate
    // falls short by at most two, so the remainder stays below 3*PRIME < 2^32
    localparam int MU_W   = 33;
    localparam int Q_LSB  = VAL_W - 1;
    localparam int REM_W  = 32;
    localparam logic [MU_W-1:0] BARRETT_MU =
        MU_W'(64'h4000_0000_0000_0000 / 64'd1000000007);

    // one multiply-accumulate request: x*y + u*w
    typedef struct packed {
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        logic [VAL_W-1:0] u;
        logic [VAL_W-1:0] w;
    } t_mac_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_VEC_HI,
        S_VEC_LO,
        S_SQ_00,
        S_SQ_01,
        S_SQ_10,
        S_SQ_11,
        S_NEXT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MM_IDLE,
        MM_MUL_A,
        MM_MUL_B,
        MM_QUOT,
        MM_PROD,
        MM_FIX
    } t_mm_state;

endpackage

// File: sv/ftm_modmac.sv
// (x*y + u*w) mod PRIME through one shared 33x33 multiplier: two products,
// a Barrett quotient estimate (reciprocal multiply), the quotient times
// PRIME, then a correction that subtracts at most two multiples of PRIME.
// o_done is high in MM_FIX, after MM_MUL_A, MM_MUL_B, MM_QUOT and MM_PROD.
module ftm_modmac (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  ftm_pkg::t_mac_req       i_req,
    output logic                    o_done,
    output logic [ftm_pkg::VAL_W-1:0] o_result
);
    import ftm_pkg::*;

    localparam int SUM_W = PROD_W + 1;
    localparam int MUL_W = 2 * MU_W;
    localparam logic [REM_W-1:0] P1 = REM_W'(PRIME);
    localparam logic [REM_W-1:0] P2 = P1 << 1;

    t_mm_state r_state, n_state;
    t_mac_req r_req;
    logic [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0] r_sum;
    logic [REM_W-1:0] r_quo;
    logic [REM_W-1:0] r_rem;
    logic [MU_W-1:0] mul_a, mul_b;
    logic [MUL_W-1:0] mul_p;
    logic [REM_W-1:0] fix_rem;

    assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MM_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (i_start) r_req <= i_req;
        case (r_state)
            MM_MUL_A: r_prod <= mul_p[PROD_W-1:0];
            MM_MUL_B: r_sum <= SUM_W'(r_prod) + SUM_W'(mul_p[PROD_W-1:0]);
            MM_QUOT:  r_quo <= mul_p[MU_W +: REM_W];
            // true remainder fits 32 bits, so the low bits subtract exactly
            MM_PROD:  r_rem <= r_sum[REM_W-1:0] - mul_p[REM_W-1:0];
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            MM_IDLE: begin
                if (i_start) n_state = MM_MUL_A;
            end
            MM_MUL_A: begin
                mul_a = MU_W'(r_req.x);
                mul_b = MU_W'(r_req.y);
                n_state = MM_MUL_B;
            end
            MM_MUL_B: begin
                mul_a = MU_W'(r_req.u);
                mul_b = MU_W'(r_req.w);
                n_state = MM_QUOT;
            end
            MM_QUOT: begin
                mul_a = MU_W'(r_sum[SUM_W-1:Q_LSB]);
                mul_b = BARRETT_MU;
                n_state = MM_PROD;
            end
            MM_PROD: begin
                mul_a = MU_W'(r_quo);
                mul_b = MU_W'(PRIME);
                n_state = MM_FIX;
            end
            MM_FIX: n_state = MM_IDLE;
            default: n_state = MM_IDLE;
        endcase
    end

    // drop the remaining one or two multiples of PRIME
    assign fix_rem = (r_rem >= P2) ? r_rem - P2 :
                     (r_rem >= P1) ? r_rem - P1 : r_rem;

    assign o_done = (r_state == MM_FIX);
    assign o_result = fix_rem[VAL_W-1:0];

endmodule

// File: sv/fibonacci_term_mod_prime.sv
// Fibonacci-like term modulo 1000000007.
//
// Input channel (s_axis): one request carries first_term, second_term and
// term_index. Output channel (m_axis): one result per request, the term
// value and an index error flag (set for index zero, value then zero).
//
// Every request is worked out by one shared modular multiply-accumulate unit
// under a small sequencer: square-and-multiply over all INDEX_WIDTH bits of
// n-2, four unit operations per bit for the square plus two vector updates
// when the bit is set. Each unit operation runs start, two products,
// quotient estimate, quotient times prime and correction. m_axis_tvalid
// rises in S_OUT after the last bit; for index zero or one it rises
// straight after S_REDUCE. Entry reduction of the two terms is a single
// compare-and-subtract.
//
// s_axis_tready is high only while the block is idle; one request is in
// work at a time, so a new request is taken only once the last result has
// been taken. The result waits in the output register until the receiver
// takes it; a stall on m_axis holds the block and the result.
// After reset the block is idle with no result pending.
module fibonacci_term_mod_prime (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [29:0] first_term, [59:30] second_term, [123:60] term_index, rest zero
    input  logic [127:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [29:0] term_value, [30] index_error, rest zero
    output logic [31:0] m_axis_tdata
);
    import ftm_pkg::*;

    t_state r_state, n_state;
    logic [VAL_W-1:0] r_t1, r_t2, r_hi, r_lo, r_p00, r_p01, r_p10, r_p11, r_nh;
    logic [VAL_W-1:0] r_q00, r_q01, r_q10;
    logic [INDEX_WIDTH-1:0] r_k;
    logic [BIT_CNT_W-1:0] r_bit;
    logic [VAL_W-1:0] r_value;
    logic r_err;
    logic r_busy;

    logic mac_start, mac_done;
    t_mac_req mac_req;
    logic [VAL_W-1:0] mac_res;

    logic [VAL_W-1:0] in_t1, in_t2;
    logic [INDEX_WIDTH-1:0] in_n;
    logic accept;

    assign in_t1 = s_axis_tdata[29:0];
    assign in_t2 = s_axis_tdata[59:30];
    assign in_n  = s_axis_tdata[60 +: INDEX_WIDTH];
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    ftm_modmac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mac_start),
        .i_req    (mac_req),
        .o_done   (mac_done),
        .o_result (mac_res)
    );

    // Issue the unit operation for the current state once, then wait on done.
    always_comb begin
        mac_req = '{x: r_p00, y: r_hi, u: r_p01, w: r_lo};
        case (r_state)
            S_VEC_LO: mac_req = '{x: r_p10, y: r_hi, u: r_p11, w: r_lo};
            S_SQ_00:  mac_req = '{x: r_p00, y: r_p00, u: r_p01, w: r_p10};
            S_SQ_01:  mac_req = '{x: r_p00, y: r_p01, u: r_p01, w: r_p11};
            S_SQ_10:  mac_req = '{x: r_p10, y: r_p00, u: r_p11, w: r_p10};
            S_SQ_11:  mac_req = '{x: r_p10, y: r_p01, u: r_p11, w: r_p11};
            default:  mac_req = '{x: r_p00, y: r_hi, u: r_p01, w: r_lo};
        endcase
    end

    assign mac_start = !r_busy && (r_state inside {S_VEC_HI, S_VEC_LO, S_SQ_00,
                                                    S_SQ_01, S_SQ_10, S_SQ_11});

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (accept) n_state = S_REDUCE;
            S_REDUCE: begin
                if (r_k == '0 || r_k == INDEX_WIDTH'(1)) n_state = S_OUT;
                else if (r_k[0]) n_state = S_VEC_HI;
                else n_state = S_SQ_00;
            end
            S_VEC_HI: if (mac_done) n_state = S_VEC_LO;
            S_VEC_LO: if (mac_done) n_state = S_SQ_00;
            S_SQ_00:  if (mac_done) n_state = S_SQ_01;
            S_SQ_01:  if (mac_done) n_state = S_SQ_10;
            S_SQ_10:  if (mac_done) n_state = S_SQ_11;
            S_SQ_11:  if (mac_done) n_state = S_NEXT;
            S_NEXT: begin
                if (r_bit == BIT_CNT_W'(INDEX_WIDTH)) n_state = S_OUT;
                else if (r_k[0]) n_state = S_VEC_HI;
                else n_state = S_SQ_00;
            end
            S_OUT:    if (m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mac_start) r_busy <= 1'b1;
            else if (mac_done) r_busy <= 1'b0;
        end

        if (accept) begin
            // terms are below 2^30 < 2*PRIME: one subtract reduces them
            r_t1 <= (in_t1 >= PRIME) ? in_t1 - PRIME : in_t1;
            r_t2 <= (in_t2 >= PRIME) ? in_t2 - PRIME : in_t2;
            r_k  <= in_n;
        end

        case (r_state)
            S_REDUCE: begin
                r_err   <= (r_k == '0);
                r_value <= (r_k == '0) ? '0 : r_t1;
                r_hi  <= r_t2;
                r_lo  <= r_t1;
                r_p00 <= VAL_W'(1);
                r_p01 <= VAL_W'(1);
                r_p10 <= VAL_W'(1);
                r_p11 <= '0;
                r_bit <= '0;
                r_k   <= r_k - INDEX_WIDTH'(2);
            end
            S_VEC_HI: if (mac_done) r_nh <= mac_res;
            S_VEC_LO: if (mac_done) begin
                r_hi <= r_nh;
                r_lo <= mac_res;
            end
            // hold the new entries until all four are done
            S_SQ_00: if (mac_done) r_q00 <= mac_res;
            S_SQ_01: if (mac_done) r_q01 <= mac_res;
            S_SQ_10: if (mac_done) r_q10 <= mac_res;
            S_SQ_11: if (mac_done) begin
                r_p00 <= r_q00;
                r_p01 <= r_q01;
                r_p10 <= r_q10;
                r_p11 <= mac_res;
                r_k   <= r_k >> 1;
                r_bit <= r_bit + 1'b1;
            end
            S_NEXT: if (r_bit == BIT_CNT_W'(INDEX_WIDTH)) r_value <= r_hi;
            default: ;
        endcase
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {1'b0, r_err, r_value};

endmodule

// File: sv/ftm_checker.sv
module ftm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed under stall");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready while result pending");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[30] |-> m_axis_tdata[29:0] == 30'd0)
        else $error("error result has nonzero value");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[29:0] < 30'd1000000007 && m_axis_tdata[31] == 1'b0)
        else $error("result out of range");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted a second request without work");
endmodule

bind fibonacci_term_mod_prime ftm_checker u_ftm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
